// ===== hw/rtl/register_machine_alu_execute_core_macros.svh =====
// Assertion macros shared by the register machine execute core RTL.
`ifndef REGISTER_MACHINE_ALU_EXECUTE_CORE_MACROS_SVH
`define REGISTER_MACHINE_ALU_EXECUTE_CORE_MACROS_SVH

`ifndef SYNTH
`define RMAE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmae assertion failed");
`define RMAE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmae assertion failed");
`else
`define RMAE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RMAE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/rmae_pkg.sv =====
// Types, opcode constants and decode function for the register machine execute core.
package rmae_pkg;

    localparam int REGISTER_COUNT_DEF = 16;
    localparam int DATA_W             = 16;
    localparam int IDX_W              = 4;
    localparam int CNT_W              = $clog2(DATA_W);

    typedef logic [3:0] t_mode;

    localparam t_mode MODE_PRINT = 4'h0;
    localparam t_mode MODE_LOAD  = 4'h1;
    localparam t_mode MODE_ADD   = 4'h2;
    localparam t_mode MODE_SUB   = 4'h3;
    localparam t_mode MODE_MUL   = 4'h4;
    localparam t_mode MODE_DIV   = 4'h5;
    localparam t_mode MODE_AND   = 4'h6;
    localparam t_mode MODE_OR    = 4'h7;
    localparam t_mode MODE_EQ    = 4'h8;
    localparam t_mode MODE_NE    = 4'h9;
    localparam t_mode MODE_LT    = 4'hA;
    localparam t_mode MODE_GT    = 4'hB;
    localparam t_mode MODE_LE    = 4'hC;
    localparam t_mode MODE_GE    = 4'hD;
    localparam t_mode MODE_NOT   = 4'hE;
    localparam t_mode MODE_SWAP  = 4'hF;

    typedef enum logic [1:0] {
        ST_OK,
        ST_JUMP,
        ST_INVALID,
        ST_DIVZERO
    } t_status;

    typedef enum logic [1:0] {
        CL_ALU,
        CL_JUMP,
        CL_AUX,
        CL_INVALID
    } t_class;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_SETUP,
        S_EXEC,
        S_FIN,
        S_SWAP,
        S_POST
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic               opcode_high;
        logic [IDX_W-1:0]   dest_index;
        logic [IDX_W-1:0]   source_index;
        logic               use_immediate;
        logic [DATA_W-1:0]  immediate;
    } t_instr;

    typedef struct packed {
        logic signed [DATA_W-1:0] dest_value;
        t_status                  status;
    } t_result;

    function automatic t_class classify(t_mode mode, logic hi);
        t_class cls;
        if (mode inside {[MODE_ADD:MODE_OR], MODE_NOT}) begin
            cls = CL_ALU;
        end else if (mode inside {[MODE_EQ:MODE_GE]}) begin
            cls = hi ? CL_JUMP : CL_ALU;
        end else if ((mode == MODE_SWAP && !hi) || (mode == MODE_PRINT && hi)
                     || mode == MODE_LOAD) begin
            cls = CL_AUX;
        end else begin
            cls = CL_INVALID;
        end
        return cls;
    endfunction

endpackage

// ===== hw/rtl/rmae_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module rmae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/register_machine_alu_execute_core.sv =====
// Top level: register machine instruction execute core with bit-serial ALU.
// ALU instructions pass S_RDA, S_RDB, S_SETUP, the serial S_EXEC loop and S_FIN; swap passes
// S_SWAP instead; load, print, jump, invalid and divide by zero go from S_SETUP straight to S_POST.
// One instruction at a time: a new one is accepted only in S_IDLE, reached once S_POST loads the output.
// Reset: synchronous active-low i_rst_n clears the control state, the output valid
// and the register valid bits, so every register reads as zero after reset.
module register_machine_alu_execute_core import rmae_pkg::*; #(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_instr  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

`include "register_machine_alu_execute_core_macros.svh"

    localparam int ADDR_W = $clog2(REGISTER_COUNT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    t_state              r_state, n_state;
    t_instr              r_ins;
    logic [ADDR_W-1:0]   r_d, r_s;
    logic [DATA_W-1:0]   r_a, r_b, r_acc, r_rem, r_res;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_carry, r_neq, r_nz, r_lt, r_neg;
    t_status             r_status;
    logic                r_out_valid;
    t_result             r_out;
    logic [REGISTER_COUNT-1:0] r_valid;
    logic                r_rd_valid;

    logic [ADDR_W-1:0]   d_slot, s_slot;
    logic [ADDR_W-1:0]   ram_raddr, ram_waddr;
    logic                ram_we;
    logic [DATA_W-1:0]   ram_wdata, ram_rdata;
    logic [DATA_W-1:0]   rd_val, opb, abs_a, abs_b, fin_val;
    t_class              cls;
    logic                in_acc, out_load;
    logic                a_bit, b_eff, sum_bit, r_bit, carry_nx;
    logic [DATA_W:0]     div_sh, div_tr;
    logic                q_bit;

    rmae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REGISTER_COUNT)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        d_slot = '0;
        s_slot = '0;
        for (int i = 0; i < (1 << IDX_W); i++) begin
            if (i_in_data.dest_index == IDX_W'(i)) begin
                d_slot = ADDR_W'(i % REGISTER_COUNT);
            end
            if (i_in_data.source_index == IDX_W'(i)) begin
                s_slot = ADDR_W'(i % REGISTER_COUNT);
            end
        end
    end

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_POST) && (!r_out_valid || i_out_ready);
    assign cls      = classify(r_ins.mode, r_ins.opcode_high);
    assign rd_val   = r_rd_valid ? ram_rdata : '0;
    assign opb      = r_ins.use_immediate ? r_ins.immediate : rd_val;
    assign abs_a    = r_a[DATA_W-1] ? -r_a : r_a;
    assign abs_b    = opb[DATA_W-1] ? -opb : opb;

    // Serial slice: one bit of add, sub, logic and compare per cycle, LSB first.
    always_comb begin
        a_bit    = r_a[0];
        b_eff    = (r_ins.mode == MODE_ADD) ? r_b[0] : ~r_b[0];
        sum_bit  = a_bit ^ b_eff ^ r_carry;
        carry_nx = (a_bit & b_eff) | (a_bit & r_carry) | (b_eff & r_carry);
        case (r_ins.mode)
            MODE_AND: r_bit = a_bit & r_b[0];
            MODE_OR:  r_bit = a_bit | r_b[0];
            default:  r_bit = sum_bit;
        endcase
    end

    // Restoring divide step on magnitudes.
    always_comb begin
        div_sh = {r_rem, r_a[DATA_W-1]};
        div_tr = div_sh - {1'b0, r_b};
        q_bit  = !div_tr[DATA_W];
    end

    always_comb begin
        case (r_ins.mode)
            MODE_MUL: fin_val = r_acc;
            MODE_DIV: fin_val = r_neg ? -r_a : r_a;
            MODE_NOT: fin_val = {{(DATA_W-1){1'b0}}, !r_nz};
            MODE_EQ:  fin_val = {{(DATA_W-1){1'b0}}, !r_neq};
            MODE_NE:  fin_val = {{(DATA_W-1){1'b0}}, r_neq};
            MODE_LT:  fin_val = {{(DATA_W-1){1'b0}}, r_lt};
            MODE_GT:  fin_val = {{(DATA_W-1){1'b0}}, !r_lt && r_neq};
            MODE_LE:  fin_val = {{(DATA_W-1){1'b0}}, r_lt || !r_neq};
            MODE_GE:  fin_val = {{(DATA_W-1){1'b0}}, !r_lt};
            default:  fin_val = r_acc;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: n_state = S_SETUP;
            S_SETUP: begin
                case (cls)
                    CL_ALU: begin
                        if (r_ins.mode == MODE_DIV && opb == '0) begin
                            n_state = S_POST;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end
                    CL_AUX: begin
                        n_state = (r_ins.mode == MODE_SWAP) ? S_SWAP : S_POST;
                    end
                    default: n_state = S_POST;
                endcase
            end
            S_EXEC: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_POST;
            S_SWAP: n_state = S_POST;
            S_POST: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        ram_raddr  = r_s;
        ram_we     = 1'b0;
        ram_waddr  = r_d;
        ram_wdata  = fin_val;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_RDA:  ram_raddr = r_d;
            S_SETUP: begin
                if (cls == CL_AUX && r_ins.mode == MODE_LOAD) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_ins.immediate;
                end else if (cls == CL_AUX && r_ins.mode == MODE_SWAP) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_val;
                end
            end
            S_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = r_s;
                ram_wdata = r_a;
            end
            S_FIN: ram_we = 1'b1;
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= r_valid[ram_raddr];
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ins <= i_in_data;
            r_d   <= d_slot;
            r_s   <= s_slot;
        end
        if (out_load) begin
            r_out.dest_value <= r_res;
            r_out.status     <= r_status;
        end
        case (r_state)
            S_RDB: r_a <= rd_val;
            S_SETUP: begin
                r_cnt    <= '0;
                r_carry  <= (r_ins.mode != MODE_ADD);
                r_neq    <= 1'b0;
                r_nz     <= 1'b0;
                r_acc    <= '0;
                r_rem    <= '0;
                r_neg    <= r_a[DATA_W-1] ^ opb[DATA_W-1];
                r_b      <= (r_ins.mode == MODE_DIV) ? abs_b : opb;
                if (r_ins.mode == MODE_DIV) begin
                    r_a <= abs_a;
                end
                case (cls)
                    CL_ALU: begin
                        r_res    <= r_a;
                        r_status <= (r_ins.mode == MODE_DIV && opb == '0) ? ST_DIVZERO
                                                                         : ST_OK;
                    end
                    CL_JUMP: begin
                        r_res    <= r_a;
                        r_status <= ST_JUMP;
                    end
                    CL_INVALID: begin
                        r_res    <= r_a;
                        r_status <= ST_INVALID;
                    end
                    default: begin
                        r_status <= ST_OK;
                        if (r_ins.mode == MODE_LOAD) begin
                            r_res <= r_ins.immediate;
                        end else if (r_ins.mode == MODE_SWAP) begin
                            r_res <= rd_val;
                        end else begin
                            r_res <= r_a;
                        end
                    end
                endcase
            end
            S_EXEC: begin
                r_cnt <= r_cnt + 1'b1;
                case (r_ins.mode)
                    MODE_MUL: begin
                        if (r_b[0]) begin
                            r_acc <= r_acc + r_a;
                        end
                        r_a <= {r_a[DATA_W-2:0], 1'b0};
                        r_b <= {1'b0, r_b[DATA_W-1:1]};
                    end
                    MODE_DIV: begin
                        r_rem <= q_bit ? div_tr[DATA_W-1:0] : div_sh[DATA_W-1:0];
                        r_a   <= {r_a[DATA_W-2:0], q_bit};
                    end
                    default: begin
                        r_acc   <= {r_bit, r_acc[DATA_W-1:1]};
                        r_carry <= carry_nx;
                        r_neq   <= r_neq | (a_bit ^ r_b[0]);
                        r_nz    <= r_nz | a_bit;
                        if (r_cnt == CNT_LAST) begin
                            r_lt <= (a_bit != r_b[0]) ? a_bit : sum_bit;
                        end
                        r_a <= {1'b0, r_a[DATA_W-1:1]};
                        r_b <= {1'b0, r_b[DATA_W-1:1]};
                    end
                endcase
            end
            S_FIN: r_res <= fin_val;
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RMAE_ASSERT_IMP(a_write_state, i_clk, i_rst_n, ram_we,
        r_state == S_SETUP || r_state == S_SWAP || r_state == S_FIN)
    `RMAE_ASSERT_IMP(a_setup_write_aux, i_clk, i_rst_n, ram_we && r_state == S_SETUP,
        r_ins.mode == MODE_LOAD || r_ins.mode == MODE_SWAP)
    `RMAE_ASSERT_NXT(a_accept_reads, i_clk, i_rst_n, in_acc, r_state == S_RDA)
    `RMAE_ASSERT_NXT(a_exec_ends, i_clk, i_rst_n, r_state == S_EXEC && r_cnt == CNT_LAST,
        r_state == S_FIN)
    `RMAE_ASSERT_NXT(a_out_from_post, i_clk, i_rst_n, !r_out_valid,
        !r_out_valid || $past(r_state) == S_POST)

endmodule
